@@ hw/rtl/urwd_pkg.sv @@
// Package for the register-write datagram builder.
// Holds frame constants, the queue entry type, the CRC-8 byte update and the frame byte lookup.
// No dependencies.
`default_nettype none

package urwd_pkg;

  // Number of serial lines the block may address.
  localparam int unsigned NUM_LINES = 2;

  localparam logic [7:0] SYNC_BYTE  = 8'h05;
  localparam logic [7:0] WRITE_FLAG = 8'h80;
  localparam logic [7:0] CRC_POLY   = 8'h07;

  // Datagram byte positions.
  localparam logic [2:0] POS_SYNC  = 3'd0;
  localparam logic [2:0] POS_SLAVE = 3'd1;
  localparam logic [2:0] POS_REG   = 3'd2;
  localparam logic [2:0] POS_DATA3 = 3'd3;
  localparam logic [2:0] POS_DATA2 = 3'd4;
  localparam logic [2:0] POS_DATA1 = 3'd5;
  localparam logic [2:0] POS_DATA0 = 3'd6;
  localparam logic [2:0] POS_CRC   = 3'd7;

  // Request queue between front and back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic        line;
    logic [7:0]  slave;
    logic [7:0]  reg_byte;
    logic [31:0] data;
  } urwd_entry_t;

  // Feed one byte into the CRC, LSB first, register shifting left.
  function automatic logic [7:0] crc_feed(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] crc;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      if (crc[7] ^ b[i]) begin
        crc = {crc[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

  // Header or data byte of an entry at a given position; CRC slot handled by caller.
  function automatic logic [7:0] frame_byte_at(input urwd_entry_t e, input logic [2:0] pos);
    logic [7:0] b;
    unique case (pos)
      POS_SYNC:  b = SYNC_BYTE;
      POS_SLAVE: b = e.slave;
      POS_REG:   b = e.reg_byte;
      POS_DATA3: b = e.data[31:24];
      POS_DATA2: b = e.data[23:16];
      POS_DATA1: b = e.data[15:8];
      POS_DATA0: b = e.data[7:0];
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/uart_register_write_datagram_top.sv @@
// Register-write datagram builder: one request in, eight datagram bytes out.
// Throughput: one byte per cycle while the output is not stalled; the back end
//   takes the next request as it emits the CRC byte of the last one.
// A request passes the queue, the back-end load and the output register.
// Reset (rst_ni low, async): queue empties, back end idles, output word drops,
//   slave address returns to 0x00.
`default_nettype none

module uart_register_write_datagram_top import urwd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: slave address
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i,
  // request word
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        axis_i,
  input  wire logic [6:0]  reg_addr_i,
  input  wire logic [31:0] write_data_i,
  // datagram byte word
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             line_select_o,
  output logic [7:0]       frame_byte_o,
  output logic [2:0]       byte_position_o,
  output logic             last_byte_o
);

  logic        q_full, q_empty, q_push, q_pop;
  urwd_entry_t q_in, q_out;

  // Front: hold the slave address, take requests, drop those for missing lines.
  urwd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .axis_i       (axis_i),
    .reg_addr_i   (reg_addr_i),
    .write_data_i (write_data_i),
    .full_i       (q_full),
    .push_o       (q_push),
    .entry_o      (q_in)
  );

  // Queue: decouple intake from serialization so each side stalls on its own.
  urwd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_in),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .empty_o      (q_empty),
    .pop_entry_o  (q_out)
  );

  // Back: advance one byte per cycle while the output is free, fold it into the CRC, emit the CRC last.
  urwd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (q_empty),
    .entry_i         (q_out),
    .pop_o           (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .line_select_o   (line_select_o),
    .frame_byte_o    (frame_byte_o),
    .byte_position_o (byte_position_o),
    .last_byte_o     (last_byte_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/urwd_front.sv @@
// Front end: slave address register, request intake and line check.
// Depends on urwd_pkg.
`default_nettype none

module urwd_front import urwd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        axis_i,
  input  wire logic [6:0]  reg_addr_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic        full_i,
  output logic             push_o,
  output urwd_entry_t      entry_o
);

  logic [7:0] slave_q, slave_d;
  logic       line_ok;

  assign cfg_ready_o = 1'b1;
  assign slave_d     = (cfg_valid_i) ? cfg_data_i : slave_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_q <= 8'h00;
    end else begin
      slave_q <= slave_d;
    end
  end

  // Drop requests for a line that does not exist.
  assign line_ok    = (int'(axis_i) < NUM_LINES);
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i && line_ok;

  always_comb begin
    entry_o.line     = axis_i;
    entry_o.slave    = slave_q;
    entry_o.reg_byte = {1'b0, reg_addr_i} | WRITE_FLAG;
    entry_o.data     = write_data_i;
  end

endmodule

`default_nettype wire

@@ hw/rtl/urwd_queue.sv @@
// Short register queue of requests between front and back.
// Depends on urwd_pkg.
`default_nettype none

module urwd_queue import urwd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire urwd_entry_t push_entry_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output urwd_entry_t pop_entry_o
);

  urwd_entry_t       mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o      = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o     = (cnt_q == '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && !empty_o;
  assign pop_entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/urwd_back.sv @@
// Back end: serialize one request into eight bytes, running CRC, output register.
// Depends on urwd_pkg.
`default_nettype none

module urwd_back import urwd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        empty_i,
  input  wire urwd_entry_t entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             line_select_o,
  output logic [7:0]       frame_byte_o,
  output logic [2:0]       byte_position_o,
  output logic             last_byte_o
);

  urwd_entry_t ent_q, ent_d;
  logic        busy_q, busy_d;
  logic [2:0]  pos_q, pos_d;
  logic [7:0]  crc_q, crc_d;
  logic        ovld_q, ovld_d;
  logic        oline_q, oline_d;
  logic [7:0]  obyte_q, obyte_d;
  logic [2:0]  opos_q, opos_d;
  logic        olast_q, olast_d;
  logic        advance, emit, at_end;
  logic [7:0]  cur_byte;

  assign advance  = !ovld_q || out_ready_i;
  assign emit     = advance && busy_q;
  assign at_end   = (pos_q == POS_CRC);
  assign pop_o    = advance && !empty_i && (!busy_q || at_end);
  assign cur_byte = at_end ? crc_q : frame_byte_at(ent_q, pos_q);

  always_comb begin
    ent_d   = ent_q;
    busy_d  = busy_q;
    pos_d   = pos_q;
    crc_d   = crc_q;
    ovld_d  = advance ? 1'b0 : ovld_q;
    oline_d = oline_q;
    obyte_d = obyte_q;
    opos_d  = opos_q;
    olast_d = olast_q;
    if (emit) begin
      ovld_d  = 1'b1;
      oline_d = ent_q.line;
      obyte_d = cur_byte;
      opos_d  = pos_q;
      olast_d = at_end;
      crc_d   = crc_feed(crc_q, cur_byte);
      pos_d   = pos_q + 3'd1;
      if (at_end) begin
        busy_d = 1'b0;
      end
    end
    if (pop_o) begin
      ent_d  = entry_i;
      busy_d = 1'b1;
      pos_d  = POS_SYNC;
      crc_d  = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= POS_SYNC;
      ovld_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q   <= ent_d;
    crc_q   <= crc_d;
    oline_q <= oline_d;
    obyte_q <= obyte_d;
    opos_q  <= opos_d;
    olast_q <= olast_d;
  end

  assign out_valid_o     = ovld_q;
  assign line_select_o   = oline_q;
  assign frame_byte_o    = obyte_q;
  assign byte_position_o = opos_q;
  assign last_byte_o     = olast_q;

`ifndef SYNTHESIS
  a_last_at_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_byte_o == (byte_position_o == POS_CRC)))
    else $error("last flag not on CRC position");
  a_sync_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (byte_position_o == POS_SYNC) |-> (frame_byte_o == SYNC_BYTE))
    else $error("first byte is not sync");
  a_no_mid_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (!busy_q || pos_q == POS_CRC))
    else $error("new request taken mid-datagram");
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !at_end |=> busy_q && (pos_q == $past(pos_q) + 3'd1))
    else $error("byte position skipped");
`endif

endmodule

`default_nettype wire
